@@ rtl/core/record_table_with_key_sort_macros.svh @@
// record_table_with_key_sort_macros.svh
// assertion macros shared by the checker, no dependencies
`ifndef RECORD_TABLE_WITH_KEY_SORT_MACROS_SVH
`define RECORD_TABLE_WITH_KEY_SORT_MACROS_SVH
// implication checked on every clock edge outside reset
`define RTKS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication outside reset
`define RTKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/rtks_pkg.sv @@
// rtks_pkg.sv
// types, constants and the sort compare for the record table; no dependencies
package rtks_pkg;
   localparam int CAPACITY = 64;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = 7;
   localparam int REC_W = 53;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_REMOVE = 3'd1;
   localparam logic [2:0] KIND_FIND   = 3'd2;
   localparam logic [2:0] KIND_SORT   = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_BADSLOT  = 2'd3;

   localparam logic [1:0] KEY_AGE  = 2'd0;
   localparam logic [1:0] KEY_YEAR = 2'd1;
   localparam logic [1:0] KEY_SEX  = 2'd2;

   typedef struct packed {
      logic              sex;
      logic [11:0]       year;
      logic [7:0]        age;
      logic signed [31:0] id;
   } rec_type;

   // true when a belongs after b
   function automatic logic goes_after(rec_type a, rec_type b, logic [1:0] key);
      logic r;
      r = 1'b0;
      case (key)
         KEY_AGE:  r = a.age > b.age;
         KEY_YEAR: r = a.year > b.year;
         KEY_SEX:  r = a.sex > b.sex;
         default:  r = 1'b0;
      endcase
      return r;
   endfunction
endpackage

@@ rtl/core/rtks_ram.sv @@
// rtks_ram.sv
// generic single-port-write, one-read ram with registered read; no dependencies
module rtks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

@@ rtl/core/record_table_with_key_sort.sv @@
// record_table_with_key_sort.sv
// record table top level; uses rtks_pkg and rtks_ram
//
//  channel  | direction | contents
//  req_     | in        | tdata: record_id, age_in, year_in, sex_in, sort_key, slot; tuser: kind
//  rsp_     | out       | tdata: status, count_now, id_out, age_out, year_out, sex_out
//  csr_     | in        | table_limit write
//
// insert, errors and unknown kinds show the result from the done state after accept, read
// passes through the read state first; find and remove scan one entry per cycle through
// the ram read port, the shift after a remove continues one entry per cycle; sort does
// one ram read per compare plus a read and a write-back per outer step.
// reset clears the count and restores the limit to 64.
// one word is in flight at a time; a held result keeps the next word out.
module record_table_with_key_sort
   import rtks_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // record_id[31:0] age_in[39:32] year_in[51:40] sex_in[52] sort_key[54:53] slot[60:55]
   input  logic [63:0]  req_tdata,
   // kind[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0] count_now[8:2] id_out[40:9] age_out[48:41] year_out[60:49] sex_out[61]
   output logic [63:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [6:0]   csr_wdata
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_SORTI = 3'd3;
   localparam logic [2:0] S_SORTJ = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;
   localparam logic [2:0] S_SORTW = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [6:0]       limit_ff;
   logic [2:0]       kind_ff, kind_in;
   logic [31:0]      id_ff, id_in;
   logic [1:0]       key_ff, key_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   rec_type          reci_ff, reci_in;
   logic             rv_ff, rv_in;
   logic [63:0]      rd_ff, rd_in;
   logic             we;
   logic [IDX_W-1:0] waddr, raddr;
   rec_type          wdata, rdata;
   logic [CNT_W-1:0] lim_eff;

   rtks_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign lim_eff = (limit_ff > 7'(CAPACITY)) ? 7'(CAPACITY) : limit_ff;
   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   function automatic logic [63:0] pack_rsp(logic [1:0] st, logic [6:0] c, rec_type r);
      return {2'b0, r.sex, r.year, r.age, r.id, c, st};
   endfunction

   // sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; kind_in = kind_ff; id_in = id_ff;
      key_in = key_ff; i_in = i_ff; j_in = j_ff; reci_in = reci_ff;
      rv_in = rv_ff; rd_in = rd_ff;
      we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in = req_tuser; id_in = req_tdata[31:0];
               key_in = req_tdata[54:53]; i_in = '0; j_in = '0;
               state_in = S_DONE;
               rd_in = pack_rsp(ST_OK, count_ff, '0);
               case (req_tuser)
                  KIND_INSERT: begin
                     if (count_ff >= lim_eff) rd_in = pack_rsp(ST_FULL, count_ff, '0);
                     else begin
                        we = 1'b1; waddr = count_ff[IDX_W-1:0];
                        wdata = req_tdata[52:0];
                        count_in = count_ff + 1'b1;
                        rd_in = pack_rsp(ST_OK, count_in, '0);
                     end
                  end
                  KIND_REMOVE, KIND_FIND: begin
                     if (count_ff == '0) rd_in = pack_rsp(ST_NOTFOUND, count_ff, '0);
                     else begin
                        raddr = '0; state_in = S_SCAN;
                     end
                  end
                  KIND_SORT: begin
                     if (count_ff > 7'd1) begin
                        raddr = '0; state_in = S_SORTI;
                        j_in = 7'd1;
                     end
                  end
                  KIND_READ: begin
                     if ({1'b0, req_tdata[60:55]} >= count_ff)
                        rd_in = pack_rsp(ST_BADSLOT, count_ff, '0);
                     else begin
                        raddr = req_tdata[60:55]; state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            rd_in = pack_rsp(ST_OK, count_ff, rdata);
            state_in = S_DONE;
         end
         S_SCAN: begin
            // rdata holds entry i
            if (rdata.id == id_ff) begin
               if (kind_ff == KIND_FIND) begin
                  rd_in = pack_rsp(ST_OK, count_ff, rdata); state_in = S_DONE;
               end else if (i_ff + 1'b1 < count_ff) begin
                  raddr = IDX_W'(i_ff + 1'b1); state_in = S_SHIFT;
               end else begin
                  count_in = count_ff - 1'b1;
                  rd_in = pack_rsp(ST_OK, count_in, '0); state_in = S_DONE;
               end
            end else if (i_ff + 1'b1 >= count_ff) begin
               rd_in = pack_rsp(ST_NOTFOUND, count_ff, '0); state_in = S_DONE;
            end else begin
               i_in = i_ff + 1'b1; raddr = IDX_W'(i_in);
            end
         end
         S_SHIFT: begin
            // rdata holds entry i+1, move it to i
            we = 1'b1; waddr = i_ff[IDX_W-1:0]; wdata = rdata;
            i_in = i_ff + 1'b1;
            if (i_in + 1'b1 < count_ff) begin
               raddr = IDX_W'(i_in + 1'b1);
            end else begin
               count_in = count_ff - 1'b1;
               rd_in = pack_rsp(ST_OK, count_in, '0); state_in = S_DONE;
            end
         end
         S_SORTI: begin
            // rdata holds entry i; then read j
            reci_in = rdata; raddr = j_ff[IDX_W-1:0]; state_in = S_SORTJ;
         end
         S_SORTJ: begin
            // rdata holds entry j; swap writes j now, i is kept in reci
            if (goes_after(reci_ff, rdata, key_ff)) begin
               we = 1'b1; waddr = j_ff[IDX_W-1:0]; wdata = reci_ff;
               reci_in = rdata;
            end
            if (j_ff + 1'b1 < count_ff) begin
               j_in = j_ff + 1'b1; raddr = IDX_W'(j_in);
            end else begin
               state_in = S_SORTW;
            end
         end
         S_SORTW: begin
            // write back record i, move to next i
            we = 1'b1; waddr = i_ff[IDX_W-1:0]; wdata = reci_ff;
            if (i_ff + 7'd2 < count_ff) begin
               i_in = i_ff + 1'b1; j_in = i_ff + 7'd2;
               raddr = IDX_W'(i_in); state_in = S_SORTI;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; limit_ff <= 7'd64; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in;
         if (csr_we) limit_ff <= csr_wdata;
      end
      kind_ff <= kind_in; id_ff <= id_in; key_ff <= key_in; i_ff <= i_in; j_ff <= j_in;
      reci_ff <= reci_in; rd_ff <= rd_in;
   end
endmodule

@@ rtl/core/rtks_checker.sv @@
// rtks_checker.sv
// port-level checker for record_table_with_key_sort; uses the macros header
`include "record_table_with_key_sort_macros.svh"
module rtks_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   // one word in flight: no accept while a result waits
   `RTKS_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "accept while result pending")
   // an accept is never answered in the same or next cycle
   `RTKS_ASSERT_NEXT(a_no_early, clock, reset, req_tvalid && req_tready, !rsp_tvalid, "result too early")
   // count never exceeds capacity
   `RTKS_ASSERT_IMP(a_count, clock, reset, rsp_tvalid, rsp_tdata[8:2] <= 7'd64, "count beyond capacity")
   // held result is stable
   `RTKS_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && rsp_tvalid, "result changed while stalled")
endmodule

bind record_table_with_key_sort rtks_checker u_rtks_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
